>>> src/rgbled_pkg.sv
package rgbled_pkg;

    localparam int EVENT_KINDS = 4;
    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = 5;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EXIT  = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_TEST  = 2'd2;
    localparam logic [1:0] KIND_ON    = 2'd3;

    localparam logic [9:0] WHEEL_STEPS = 10'd765;
    localparam logic [9:0] WHEEL_TWO   = 10'd510;
    localparam logic [9:0] WHEEL_ONE   = 10'd255;
    localparam logic [7:0] GREY_FULL   = 8'd255;

    // ceil(2^26 / 765): exact quotient by 765 for any 16-bit dividend
    localparam logic [16:0] WHEEL_RECIP = 17'd87725;
    localparam int          WHEEL_SHIFT = 26;

    typedef enum logic [2:0] {
        REG_PERIOD_RESET = 3'd0,
        REG_PERIOD_TEST  = 3'd1,
        REG_PERIOD_ON    = 3'd2,
        REG_WHEEL_DIV    = 3'd3,
        REG_GREY_STEP    = 3'd4,
        REG_PWM_PERIOD   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  led_number;
        logic [1:0]  event_kind;
        logic [15:0] loop_count;
    } item_in_t;

    typedef struct packed {
        logic [1:0]  shown_event;
        logic [15:0] red_on_count;
        logic [15:0] green_on_count;
        logic [15:0] blue_on_count;
        logic [2:0]  channels_running;
        logic        power_on;
        logic        sleep_allowed;
    } item_out_t;

    typedef struct packed {
        logic [15:0] period_reset_event;
        logic [15:0] period_test_event;
        logic [15:0] period_on_event;
        logic [7:0]  wheel_divider;
        logic [8:0]  grey_step;
        logic [15:0] pwm_period;
    } cfg_t;

    typedef enum logic [1:0] {
        DIV_WHEEL = 2'd0,
        DIV_MOD   = 2'd1,
        DIV_LOOP  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic       load_item;
        logic       apply_op;
        logic       div_start;
        div_sel_t   div_sel;
        logic       drive;
        logic       loop_apply;
        logic       tick_finish;
        logic       out_load;
        logic [1:0] kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       any_active;
        logic       loop_due;
        logic       div_busy;
        logic       out_full;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WHEEL_DIV,
        ST_MOD_DIV,
        ST_DRIVE,
        ST_LOOP_CHK,
        ST_LOOP_DIV,
        ST_LOOP_APPLY,
        ST_FINISH,
        ST_DONE
    } ctl_state_t;

endpackage

>>> src/rgb_led_effect_sequencer_unit.sv
// Channel   Ports                                   Direction
// s_        s_valid, s_ready, s_data (item_in_t)    item in: tick, start, exit
// m_        m_valid, m_ready, m_data (item_out_t)   item out: one per input item
// apb       psel, penable, pwrite, paddr, pwdata    register access, pready tied high
//
// Start, exit and ticks with no event set pass from decode to the output hand-off.
// A tick with events set runs the shared 16-step serial divider once for the wheel
// step, then a reciprocal multiply and subtract for the phase mod 765, and one
// divider pass per due event, three passes with all three due.
// Reset (aresetn low, synchronous) clears all event state; registers take defaults.
// One item at a time; s_ready drops until the result is in the output register.
module rgb_led_effect_sequencer_unit
    import rgbled_pkg::*;
#(
    parameter int OWN_LED_INDEX = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  item_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output item_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_reset_event <= 16'd500;
            cfg_reg.period_test_event  <= 16'd500;
            cfg_reg.period_on_event    <= 16'd500;
            cfg_reg.wheel_divider      <= 8'd5;
            cfg_reg.grey_step          <= 9'd1;
            cfg_reg.pwm_period         <= 16'd256;
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                REG_PERIOD_RESET: cfg_reg.period_reset_event <= pwdata[15:0];
                REG_PERIOD_TEST:  cfg_reg.period_test_event  <= pwdata[15:0];
                REG_PERIOD_ON:    cfg_reg.period_on_event    <= pwdata[15:0];
                REG_WHEEL_DIV:    cfg_reg.wheel_divider      <= pwdata[7:0];
                REG_GREY_STEP:    cfg_reg.grey_step          <= pwdata[8:0];
                REG_PWM_PERIOD:   cfg_reg.pwm_period         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PERIOD_RESET: prdata = {16'd0, cfg_reg.period_reset_event};
            REG_PERIOD_TEST:  prdata = {16'd0, cfg_reg.period_test_event};
            REG_PERIOD_ON:    prdata = {16'd0, cfg_reg.period_on_event};
            REG_WHEEL_DIV:    prdata = {24'd0, cfg_reg.wheel_divider};
            REG_GREY_STEP:    prdata = {23'd0, cfg_reg.grey_step};
            REG_PWM_PERIOD:   prdata = {16'd0, cfg_reg.pwm_period};
            default:          prdata = 32'd0;
        endcase
    end

    rgbled_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rgbled_dp #(
        .OWN_LED_INDEX (OWN_LED_INDEX)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .status  (status)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in flight");

    a_sleep_no_channels: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sleep_allowed) |-> (m_data.channels_running == 3'd0))
        else $error("sleep allowed with channels running");

    a_idle_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.shown_event == KIND_NONE) |->
        (m_data.red_on_count == 16'd0 && m_data.green_on_count == 16'd0
         && m_data.blue_on_count == 16'd0 && !m_data.power_on))
        else $error("led driven with no event shown");
`endif

endmodule

>>> src/rgbled_ctrl.sv
module rgbled_ctrl
    import rgbled_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_RESET;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.operation == OP_TICK && status.any_active) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_WHEEL;
                    state_next    = ST_WHEEL_DIV;
                end else begin
                    cmd.apply_op = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_WHEEL_DIV: begin
                if (!status.div_busy) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MOD;
                    state_next    = ST_MOD_DIV;
                end
            end
            ST_MOD_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                cmd.drive  = 1'b1;
                kind_next  = KIND_RESET;
                state_next = ST_LOOP_CHK;
            end
            ST_LOOP_CHK: begin
                if (status.loop_due) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_LOOP;
                    state_next    = ST_LOOP_DIV;
                end else if (kind_reg == KIND_ON) begin
                    state_next = ST_FINISH;
                end else begin
                    kind_next = kind_reg + 2'd1;
                end
            end
            ST_LOOP_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_LOOP_APPLY;
                end
            end
            ST_LOOP_APPLY: begin
                cmd.loop_apply = 1'b1;
                if (kind_reg == KIND_ON) begin
                    state_next = ST_FINISH;
                end else begin
                    kind_next  = kind_reg + 2'd1;
                    state_next = ST_LOOP_CHK;
                end
            end
            ST_FINISH: begin
                cmd.tick_finish = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_full || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> src/rgbled_dp.sv
module rgbled_dp
    import rgbled_pkg::*;
#(
    parameter int OWN_LED_INDEX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  item_in_t   s_data,
    input  logic       m_ready,
    output logic       m_valid,
    output item_out_t  m_data,
    input  cfg_t       cfg,
    input  dp_cmd_t    cmd,
    output dp_status_t status
);

    localparam logic [7:0] OWN_LED = 8'(OWN_LED_INDEX);

    item_in_t    item_reg;
    logic [15:0] tick_reg;
    logic [3:0]  active_reg;
    logic [1:0]  shown_reg;
    logic [15:0] loops_reg  [EVENT_KINDS];
    logic [15:0] offset_reg [EVENT_KINDS];
    logic [7:0]  grey_reg   [3];
    logic [15:0] on_reg     [3];
    logic [2:0]  running_reg;
    logic        boost_reg;
    logic        busy_reg;

    logic [DIV_W-1:0]     rem_reg, quo_reg, dvsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 mod_reg;

    item_out_t out_reg;
    logic      out_valid_reg;

    // serial restoring divider, one quotient bit per cycle
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W-1:0] dvd_sel, dvsr_sel, period_k;
    logic             rem_ge;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, dvsr_reg};

    // wheel phase mod 765: reciprocal multiply, then subtract
    logic [32:0] recip_prod;
    logic [16:0] mod_sub;

    assign recip_prod = 33'(quo_reg) * 33'(WHEEL_RECIP);
    assign mod_sub    = 17'(quo_reg) * 17'(WHEEL_STEPS);

    always_comb begin
        case (cmd.kind)
            KIND_RESET: period_k = cfg.period_reset_event;
            KIND_TEST:  period_k = cfg.period_test_event;
            default:    period_k = cfg.period_on_event;
        endcase
        case (cmd.div_sel)
            DIV_WHEEL: begin
                dvd_sel  = tick_reg;
                dvsr_sel = (cfg.wheel_divider == 8'd0) ? 16'd1 : {8'd0, cfg.wheel_divider};
            end
            DIV_MOD: begin
                dvd_sel  = quo_reg;
                dvsr_sel = {6'd0, WHEEL_STEPS};
            end
            default: begin
                dvd_sel  = tick_reg + offset_reg[cmd.kind];
                dvsr_sel = (period_k == 16'd0) ? 16'd1 : period_k;
            end
        endcase
    end

    // wheel colour from the phase held in the remainder
    logic [9:0] phase;
    logic [7:0] grey_new [3];
    logic [1:0] shown_new;

    assign phase = rem_reg[9:0];

    always_comb begin
        if (active_reg[1])      shown_new = KIND_RESET;
        else if (active_reg[2]) shown_new = KIND_TEST;
        else if (active_reg[3]) shown_new = KIND_ON;
        else                    shown_new = KIND_NONE;
        grey_new[0] = grey_reg[0];
        grey_new[1] = grey_reg[1];
        grey_new[2] = grey_reg[2];
        if (shown_new == KIND_RESET) begin
            grey_new[0] = GREY_FULL;
            grey_new[1] = GREY_FULL;
            grey_new[2] = GREY_FULL;
        end else if (shown_new == KIND_TEST) begin
            if (phase <= WHEEL_ONE) begin
                grey_new[0] = 8'(WHEEL_ONE - phase);
                grey_new[1] = phase[7:0];
                grey_new[2] = 8'd0;
            end else if (phase <= WHEEL_TWO) begin
                grey_new[0] = 8'd0;
                grey_new[1] = 8'(WHEEL_TWO - phase);
                grey_new[2] = 8'(phase - WHEEL_ONE);
            end else begin
                grey_new[0] = 8'(phase - WHEEL_TWO);
                grey_new[1] = 8'd0;
                grey_new[2] = 8'(WHEEL_STEPS - phase);
            end
        end
    end

    function automatic logic [15:0] on_count(input logic [7:0] grey, input cfg_t c);
        logic [17:0] prod;
        logic [17:0] on_full;
        logic [15:0] top;
        prod    = 18'({1'b0, grey} + 9'd1) * 18'(c.grey_step);
        on_full = (prod == 18'd0) ? 18'd0 : prod - 18'd1;
        top     = (c.pwm_period == 16'd0) ? 16'd0 : c.pwm_period - 16'd1;
        if (grey == 8'd0) begin
            return 16'd0;
        end else if (on_full > {2'b00, top}) begin
            return top;
        end else begin
            return on_full[15:0];
        end
    endfunction

    logic [15:0] on_new [3];
    assign on_new[0] = on_count(grey_new[0], cfg);
    assign on_new[1] = on_count(grey_new[1], cfg);
    assign on_new[2] = on_count(grey_new[2], cfg);

    logic [3:0] kind_bit, item_bit;
    assign kind_bit = 4'b0001 << cmd.kind;
    assign item_bit = 4'b0001 << item_reg.event_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            active_reg    <= '0;
            shown_reg     <= KIND_NONE;
            running_reg   <= '0;
            boost_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            mod_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < EVENT_KINDS; k++) begin
                loops_reg[k]  <= '0;
                offset_reg[k] <= '0;
            end
            for (int c = 0; c < 3; c++) begin
                grey_reg[c] <= '0;
                on_reg[c]   <= '0;
            end
        end else begin
            if (cmd.load_item) begin
                item_reg <= s_data;
            end

            if (cmd.div_start && cmd.div_sel == DIV_MOD) begin
                quo_reg <= 16'(recip_prod[32:WHEEL_SHIFT]);
                rem_reg <= quo_reg;
                cnt_reg <= DIV_CNT_W'(1);
                mod_reg <= 1'b1;
            end else if (cmd.div_start) begin
                quo_reg  <= dvd_sel;
                rem_reg  <= '0;
                dvsr_reg <= dvsr_sel;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end else if (mod_reg) begin
                rem_reg <= rem_reg - mod_sub[15:0];
                cnt_reg <= '0;
                mod_reg <= 1'b0;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
                rem_reg <= rem_ge ? DIV_W'(rem_shift - {1'b0, dvsr_reg}) : rem_shift[DIV_W-1:0];
            end

            if (cmd.apply_op) begin
                unique case (item_reg.operation)
                    OP_TICK: begin
                        shown_reg <= KIND_NONE;
                        tick_reg  <= tick_reg + 16'd1;
                    end
                    OP_START: begin
                        if (item_reg.led_number == OWN_LED && item_reg.event_kind != KIND_NONE) begin
                            active_reg <= active_reg | item_bit;
                            loops_reg[item_reg.event_kind]  <= item_reg.loop_count;
                            offset_reg[item_reg.event_kind] <= 16'd0 - tick_reg;
                            busy_reg <= 1'b1;
                        end
                    end
                    OP_EXIT: begin
                        if (item_reg.led_number == OWN_LED && item_reg.event_kind != KIND_NONE
                            && (active_reg & item_bit) != 4'd0) begin
                            active_reg <= active_reg & ~item_bit;
                            if ((active_reg & ~item_bit) == 4'd0) begin
                                running_reg <= '0;
                                boost_reg   <= 1'b0;
                                busy_reg    <= 1'b0;
                                shown_reg   <= KIND_NONE;
                                tick_reg    <= '0;
                                for (int c = 0; c < 3; c++) begin
                                    grey_reg[c] <= '0;
                                    on_reg[c]   <= '0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.drive) begin
                shown_reg <= shown_new;
                boost_reg <= 1'b1;
                for (int c = 0; c < 3; c++) begin
                    if (grey_new[c] != grey_reg[c]) begin
                        grey_reg[c]    <= grey_new[c];
                        on_reg[c]      <= on_new[c];
                        running_reg[c] <= 1'b1;
                    end
                end
            end

            // loop boundary when the offset tick count divides evenly
            if (cmd.loop_apply && rem_reg == '0) begin
                loops_reg[cmd.kind] <= loops_reg[cmd.kind] - 16'd1;
                if (loops_reg[cmd.kind] == 16'd1) begin
                    active_reg <= active_reg & ~kind_bit;
                    if ((active_reg & ~kind_bit) == 4'd0) begin
                        running_reg <= '0;
                        boost_reg   <= 1'b0;
                        busy_reg    <= 1'b0;
                        shown_reg   <= KIND_NONE;
                        tick_reg    <= '0;
                        for (int c = 0; c < 3; c++) begin
                            grey_reg[c] <= '0;
                            on_reg[c]   <= '0;
                        end
                    end
                end
            end

            if (cmd.tick_finish) begin
                tick_reg <= tick_reg + 16'd1;
            end

            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.shown_event      <= shown_reg;
            out_reg.red_on_count     <= on_reg[0];
            out_reg.green_on_count   <= on_reg[1];
            out_reg.blue_on_count    <= on_reg[2];
            out_reg.channels_running <= running_reg;
            out_reg.power_on         <= boost_reg;
            out_reg.sleep_allowed    <= (running_reg == '0) && !busy_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign status.operation  = item_reg.operation;
    assign status.any_active = active_reg != 4'd0;
    assign status.loop_due   = ((active_reg & kind_bit) != 4'd0)
                               && loops_reg[cmd.kind] != 16'd0 && tick_reg != 16'd0;
    assign status.div_busy   = cnt_reg != '0;
    assign status.out_full   = out_valid_reg;

endmodule

>>> tb/rgb_led_effect_sequencer_unit_test.sv
module rgb_led_effect_sequencer_unit_test;
    import rgbled_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    item_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    item_out_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rgb_led_effect_sequencer_unit dut (.*);

    always #2 aclk = ~aclk;

    // shadow of block state
    logic [15:0] period_reg [1:3];
    logic [7:0]  wheel_div_reg;
    logic [8:0]  grey_step_reg;
    logic [15:0] pwm_period_reg;
    logic [15:0] tick_cnt;
    logic [3:0]  events_set;
    logic [1:0]  kind_shown;
    logic [15:0] loops_remaining [0:3];
    logic [15:0] tick_offset [0:3];
    logic [7:0]  grey_now [0:2];
    logic [15:0] on_count [0:2];
    logic [2:0]  run_bits;
    logic        boost;
    logic        busy;

    item_out_t   pending_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          quiet_sink = 1'b0;
    bit          quiet_source = 1'b0;

    function automatic void stop_all();
        for (int c = 0; c < 3; c++) begin
            grey_now[c] = '0;
            on_count[c] = '0;
        end
        run_bits = '0;
        boost = 1'b0;
        busy = 1'b0;
        kind_shown = KIND_NONE;
        tick_cnt = '0;
    endfunction

    function automatic void shadow_reset();
        for (int k = 1; k < 4; k++) period_reg[k] = 16'd500;
        wheel_div_reg = 8'd5;
        grey_step_reg = 9'd1;
        pwm_period_reg = 16'd256;
        events_set = '0;
        for (int k = 0; k < 4; k++) begin
            loops_remaining[k] = '0;
            tick_offset[k] = '0;
        end
        stop_all();
    endfunction

    function automatic void set_channel(int c, logic [7:0] grey);
        logic [31:0] prod;
        logic [31:0] on;
        logic [31:0] top;
        on = 0;
        if (grey == grey_now[c]) return;
        if (grey != 0) begin
            prod = (32'(grey) + 1) * 32'(grey_step_reg);
            on = (prod == 0) ? 0 : prod - 1;
            top = (pwm_period_reg > 0) ? 32'(pwm_period_reg) - 1 : 0;
            if (on > top) on = top;
        end
        on_count[c] = on[15:0];
        run_bits[c] = 1'b1;
        grey_now[c] = grey;
    endfunction

    function automatic void advance_tick();
        logic [7:0]  g [0:2];
        logic [31:0] div;
        logic [31:0] phase;
        logic [31:0] per;
        logic [15:0] cur;
        kind_shown = KIND_NONE;
        for (int k = 3; k >= 0; k--)
            if (events_set[k]) kind_shown = 2'(k);
        if (events_set != 0) begin
            div = (wheel_div_reg == 0) ? 1 : 32'(wheel_div_reg);
            phase = (32'(tick_cnt) / div) % 765;
            if (kind_shown == KIND_RESET) begin
                g[0] = GREY_FULL; g[1] = GREY_FULL; g[2] = GREY_FULL;
            end else if (kind_shown == KIND_TEST) begin
                if (phase <= 255) begin
                    g[0] = 8'(255 - phase); g[1] = 8'(phase); g[2] = 0;
                end else if (phase <= 510) begin
                    g[0] = 0; g[1] = 8'(510 - phase); g[2] = 8'(phase - 255);
                end else begin
                    g[0] = 8'(phase - 510); g[1] = 0; g[2] = 8'(765 - phase);
                end
            end else begin
                for (int c = 0; c < 3; c++) g[c] = grey_now[c];
            end
            boost = 1'b1;
            for (int c = 0; c < 3; c++) set_channel(c, g[c]);
            for (int k = 1; k < 4; k++) begin
                if (!events_set[k]) continue;
                cur = tick_cnt + tick_offset[k];
                per = (period_reg[k] == 0) ? 1 : 32'(period_reg[k]);
                if (loops_remaining[k] > 0 && tick_cnt != 0 && (32'(cur) % per) == 0) begin
                    loops_remaining[k]--;
                    if (loops_remaining[k] == 0) begin
                        events_set[k] = 1'b0;
                        if (events_set == 0) stop_all();
                    end
                end
            end
        end
        tick_cnt = tick_cnt + 16'd1;
    endfunction

    function automatic item_out_t predict_led(item_in_t it);
        item_out_t r;
        if (it.operation == OP_TICK) begin
            advance_tick();
        end else if (it.operation == OP_START) begin
            if (it.led_number == 0 && it.event_kind != KIND_NONE) begin
                events_set[it.event_kind] = 1'b1;
                loops_remaining[it.event_kind] = it.loop_count;
                tick_offset[it.event_kind] = 16'd0 - tick_cnt;
                busy = 1'b1;
            end
        end else if (it.operation == OP_EXIT) begin
            if (it.led_number == 0 && it.event_kind != KIND_NONE
                    && events_set[it.event_kind]) begin
                events_set[it.event_kind] = 1'b0;
                if (events_set == 0) stop_all();
            end
        end
        r.shown_event = kind_shown;
        r.red_on_count = on_count[0];
        r.green_on_count = on_count[1];
        r.blue_on_count = on_count[2];
        r.channels_running = run_bits;
        r.power_on = boost;
        r.sleep_allowed = (run_bits == 0 && !busy);
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        item_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_PERIOD_RESET: period_reg[1] = value;
            REG_PERIOD_TEST:  period_reg[2] = value;
            REG_PERIOD_ON:    period_reg[3] = value;
            REG_WHEEL_DIV:    wheel_div_reg = value[7:0];
            REG_GREY_STEP:    grey_step_reg = value[8:0];
            REG_PWM_PERIOD:   pwm_period_reg = value;
            default: ;
        endcase
    endtask

    // send one item; optional typed expectation is compared to the predictor
    // valid stays up between back-to-back items and drops only while idling
    task automatic send_item(item_in_t it, bit has_fixed, item_out_t fixed);
        item_out_t want;
        if (!quiet_source && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 21);
        end
        want = predict_led(it);
        if (has_fixed && want !== fixed) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row: expected %h model %h", fixed, want);
        end
        pending_results.push_back(want);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic item_in_t mk(logic [1:0] op, logic [7:0] led, logic [1:0] kind,
                                    logic [15:0] cnt);
        item_in_t it;
        it.operation = op; it.led_number = led; it.event_kind = kind; it.loop_count = cnt;
        return it;
    endfunction

    function automatic item_out_t idle_out();
        item_out_t r;
        r = '0;
        r.sleep_allowed = 1'b1;
        return r;
    endfunction

    typedef struct {
        item_in_t  stim;
        bit        fixed;
        item_out_t result;
    } row_t;

    item_in_t rnd;
    row_t     rows [$];
    item_out_t busy_out;
    item_out_t white;
    int       burst;

    initial begin
        shadow_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        busy_out = '0;
        white = '0;
        white.shown_event = KIND_RESET;
        white.red_on_count = 16'd255; white.green_on_count = 16'd255;
        white.blue_on_count = 16'd255;
        white.channels_running = 3'b111; white.power_on = 1'b1;
        rows = '{
            '{mk(OP_TICK, 8'hFF, KIND_ON, 16'hFFFF), 1, idle_out()},
            '{mk(OP_EXIT, 8'd0, KIND_TEST, 16'd0), 1, idle_out()},
            '{mk(OP_START, 8'd7, KIND_RESET, 16'd1), 1, idle_out()},
            '{mk(OP_START, 8'd0, KIND_NONE, 16'd1), 1, idle_out()},
            '{mk(2'd3, 8'd0, KIND_RESET, 16'd1), 1, idle_out()},
            '{mk(OP_START, 8'd0, KIND_RESET, 16'd0), 1, busy_out},
            '{mk(OP_TICK, 8'd0, KIND_NONE, 16'd0), 1, white},
            '{mk(OP_TICK, 8'd0, KIND_NONE, 16'd0), 0, '0},
            '{mk(OP_START, 8'd0, KIND_TEST, 16'd2), 0, '0},
            '{mk(OP_EXIT, 8'd0, KIND_RESET, 16'd0), 0, '0},
            '{mk(OP_TICK, 8'd0, KIND_NONE, 16'd0), 0, '0},
            '{mk(OP_START, 8'd0, KIND_ON, 16'hFFFF), 0, '0},
            '{mk(OP_START, 8'd0, KIND_ON, 16'd3), 0, '0},
            '{mk(OP_TICK, 8'd0, KIND_NONE, 16'd0), 0, '0},
            '{mk(OP_EXIT, 8'd0, KIND_TEST, 16'd0), 0, '0},
            '{mk(OP_TICK, 8'd0, KIND_NONE, 16'd0), 0, '0},
            '{mk(OP_EXIT, 8'd0, KIND_ON, 16'd0), 1, idle_out()},
            '{mk(OP_EXIT, 8'd0, KIND_ON, 16'd0), 1, idle_out()}
        };
        foreach (rows[i]) send_item(rows[i].stim, rows[i].fixed, rows[i].result);
        drain();

        // random phases over several register settings, extremes first
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_PERIOD_RESET, 16'd1); write_reg(REG_PERIOD_TEST, 16'd1);
                    write_reg(REG_PERIOD_ON, 16'd1); write_reg(REG_WHEEL_DIV, 16'd1);
                    write_reg(REG_GREY_STEP, 16'd256); write_reg(REG_PWM_PERIOD, 16'd2);
                end
                1: begin
                    write_reg(REG_PERIOD_RESET, 16'hFFFF); write_reg(REG_PERIOD_TEST, 16'hFFFF);
                    write_reg(REG_PERIOD_ON, 16'hFFFF); write_reg(REG_WHEEL_DIV, 16'd255);
                    write_reg(REG_GREY_STEP, 16'd1); write_reg(REG_PWM_PERIOD, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_PERIOD_RESET, 16'($urandom_range(1, 12)));
                    write_reg(REG_PERIOD_TEST, 16'($urandom_range(1, 12)));
                    write_reg(REG_PERIOD_ON, 16'($urandom_range(1, 12)));
                    write_reg(REG_WHEEL_DIV, 16'($urandom_range(1, 255)));
                    write_reg(REG_GREY_STEP, 16'($urandom_range(1, 256)));
                    write_reg(REG_PWM_PERIOD, 16'($urandom_range(2, 65535)));
                end
            endcase
            quiet_source = (phase == 3);
            quiet_sink = (phase == 3);
            for (int n = 0; n < 200; n++) begin
                rnd = item_in_t'(28'($urandom));
                burst = $urandom_range(99);
                if (burst < 60) rnd.operation = OP_TICK;
                else if (burst < 80) begin
                    rnd.operation = OP_START;
                    if ($urandom_range(3) != 0) rnd.led_number = 8'd0;
                    if ($urandom_range(3) != 0) rnd.loop_count = 16'($urandom_range(0, 5));
                end else if (burst < 95) begin
                    rnd.operation = OP_EXIT;
                    if ($urandom_range(3) != 0) rnd.led_number = 8'd0;
                end
                send_item(rnd, 0, '0);
            end
            drain();
        end
        quiet_source = 0;
        quiet_sink = 0;

        $display("covered directed rows plus 1200 random ticks, starts and exits");
        $display("over 6 register settings; %0d results checked", results_seen);
        if (mismatches == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
